// ----- src/glyph_framebuffer_page_packer_top_defines.svh -----
// Assertion macros used by the control module.
`ifndef GLYPH_FRAMEBUFFER_PAGE_PACKER_TOP_DEFINES_SVH
`define GLYPH_FRAMEBUFFER_PAGE_PACKER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GFPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GFPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gfpp_pkg.sv -----
`default_nettype none

package gfpp_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 4;

    localparam logic [7:0] KEEP_MASK        = 8'h81;
    localparam logic [7:0] CODE_ZERO        = 8'd48;
    localparam logic [7:0] CODE_NINE        = 8'h39;
    localparam logic [7:0] CODE_A           = 8'h41;
    localparam logic [7:0] CODE_Z           = 8'h5A;
    localparam logic [5:0] GLYPH_DIGIT_BASE = 6'd26;
    localparam logic [5:0] GLYPH_NONE       = 6'd63;
    localparam int         GLYPH_ROWS       = 6;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_CLR,
        ST_WR_RD,
        ST_WR_WR,
        ST_RD_RD,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_en;
        logic rd_en;
        logic wr_en;
        logic respond;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       page_ok;
        logic       read_ok;
        logic       col_ok;
        logic       col_last;
        logic       clr_last;
    } dp_status_t;

    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [5:0] idx;
        idx = GLYPH_NONE;
        if (code >= CODE_ZERO && code <= CODE_NINE)
        begin
            idx = GLYPH_DIGIT_BASE + 6'(code - CODE_ZERO);
        end
        else if (code >= CODE_A && code <= CODE_Z)
        begin
            idx = 6'(code - CODE_A);
        end
        return idx;
    endfunction

    // Six glyph rows, first row in the top byte, bit 7 of each row is the leftmost column.
    function automatic logic [47:0] glyph_rows(input logic [5:0] idx);
        logic [47:0] rows;
        unique case (idx)
            6'd0:    rows = 48'h18243C424242;
            6'd1:    rows = 48'h3824383C223C;
            6'd2:    rows = 48'h1C224040221C;
            6'd3:    rows = 48'h784442424478;
            6'd4:    rows = 48'h3C203820203C;
            6'd5:    rows = 48'h3C2038202020;
            6'd6:    rows = 48'h1C22404E423E;
            6'd7:    rows = 48'h24243C242424;
            6'd8:    rows = 48'h1C080808081C;
            6'd9:    rows = 48'h0E0404042418;
            6'd10:   rows = 48'h485060504844;
            6'd11:   rows = 48'h20202020203C;
            6'd12:   rows = 48'h42665A424242;
            6'd13:   rows = 48'h4262524A4642;
            6'd14:   rows = 48'h182442422418;
            6'd15:   rows = 48'h382438202020;
            6'd16:   rows = 48'h1824424A241A;
            6'd17:   rows = 48'h382438242422;
            6'd18:   rows = 48'h182018042418;
            6'd19:   rows = 48'h3E0808080808;
            6'd20:   rows = 48'h242424242418;
            6'd21:   rows = 48'h424224242418;
            6'd22:   rows = 48'h8181425A5A24;
            6'd23:   rows = 48'h422418182442;
            6'd24:   rows = 48'h22221C080808;
            6'd25:   rows = 48'h3C040810203C;
            6'd26:   rows = 48'h182424242418;
            6'd27:   rows = 48'h08180808081C;
            6'd28:   rows = 48'h1C22020C103E;
            6'd29:   rows = 48'h3E040C02221C;
            6'd30:   rows = 48'h040C143E0404;
            6'd31:   rows = 48'h3E203C02221C;
            6'd32:   rows = 48'h182038242418;
            6'd33:   rows = 48'h3C0408081010;
            6'd34:   rows = 48'h182418242418;
            6'd35:   rows = 48'h1824241C0418;
            default: rows = 48'h000000000000;
        endcase
        return rows;
    endfunction

    // Packed column byte of a glyph; rows 1 to 6 of the page carry glyph rows 0 to 5.
    function automatic logic [7:0] glyph_column(input logic [5:0] idx, input logic [2:0] j);
        logic [47:0] rows;
        logic [7:0]  row;
        logic [7:0]  v;
        rows = glyph_rows(idx);
        v    = 8'h00;
        for (int i = 0; i < GLYPH_ROWS; i++)
        begin
            row      = rows[8 * (GLYPH_ROWS - 1 - i) +: 8];
            v[i + 1] = row[~j];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/gfpp_datapath.sv -----
`default_nettype none

module gfpp_datapath #(
    parameter int COLUMNS = gfpp_pkg::COLUMNS_DEF,
    parameter int PAGES   = gfpp_pkg::PAGES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire gfpp_pkg::ctrl_cmd_t   cmd,
    input  wire logic [1:0]            func,
    input  wire logic [7:0]            char_code,
    input  wire logic [1:0]            page,
    input  wire logic [6:0]            column,
    output gfpp_pkg::dp_status_t       status,
    output logic [7:0]                 column_byte,
    output logic                       is_read_data,
    output logic                       done
);

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = ($clog2(COLUMNS + 1) > 8) ? $clog2(COLUMNS + 1) : 8;
    localparam int ABW    = AW + CNT_W;

    logic [7:0]    mem [DEPTH];

    logic [1:0]    func_reg;
    logic [5:0]    glyph_reg;
    logic [1:0]    page_reg;
    logic [6:0]    col_reg;
    logic [2:0]    j_reg,     j_next;
    logic [AW-1:0] sweep_reg, sweep_next;
    logic          done_reg,  done_next;
    logic [7:0]    rdata_reg;
    logic [7:0]    column_byte_reg;
    logic          is_read_reg;

    logic [CNT_W-1:0] cur_col;
    logic [ABW-1:0]   addr_full;
    logic [AW-1:0]    addr;
    logic             page_ok;
    logic             read_ok;
    logic             clr_last;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;

    always_comb
    begin
        cur_col   = CNT_W'(col_reg) + CNT_W'(j_reg);
        addr_full = ABW'(page_reg) * ABW'(COLUMNS) + ABW'(cur_col);
        addr      = addr_full[AW-1:0];
        page_ok   = 32'(page_reg) < PAGES;
        read_ok   = page_ok && (CNT_W'(col_reg) < CNT_W'(COLUMNS));
        clr_last  = sweep_reg == AW'(DEPTH - 1);

        status.func     = func_reg;
        status.page_ok  = page_ok;
        status.read_ok  = read_ok;
        status.col_ok   = cur_col < CNT_W'(COLUMNS);
        status.col_last = j_reg == 3'd7;
        status.clr_last = clr_last;

        mem_we    = cmd.clr_en || cmd.wr_en;
        mem_waddr = cmd.clr_en ? sweep_reg : addr;
        mem_wdata = cmd.clr_en ? 8'h00
                  : ((rdata_reg & gfpp_pkg::KEEP_MASK) | gfpp_pkg::glyph_column(glyph_reg, j_reg));

        j_next = j_reg;
        if (cmd.load)
        begin
            j_next = 3'd0;
        end
        else if (cmd.wr_en)
        begin
            j_next = j_reg + 3'd1;
        end

        sweep_next = sweep_reg;
        if (cmd.clr_en)
        begin
            sweep_next = clr_last ? '0 : sweep_reg + AW'(1);
        end

        done_next = cmd.respond;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg     <= 3'd0;
            sweep_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            j_reg     <= j_next;
            sweep_reg <= sweep_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            glyph_reg <= gfpp_pkg::glyph_index(char_code);
            page_reg  <= page;
            col_reg   <= column;
        end
        if (cmd.respond)
        begin
            is_read_reg     <= func_reg == gfpp_pkg::FUNC_READ;
            column_byte_reg <= (func_reg == gfpp_pkg::FUNC_READ && read_ok) ? rdata_reg : 8'h00;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign column_byte  = column_byte_reg;
    assign is_read_data = is_read_reg;
    assign done         = done_reg;

endmodule

`default_nettype wire

// ----- src/gfpp_ctrl.sv -----
`default_nettype none

`include "glyph_framebuffer_page_packer_top_defines.svh"

module gfpp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire gfpp_pkg::dp_status_t  status,
    output gfpp_pkg::ctrl_cmd_t        cmd,
    output logic                       busy
);

    gfpp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gfpp_pkg::ST_INIT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = state_reg != gfpp_pkg::ST_IDLE;
        unique case (state_reg)
            gfpp_pkg::ST_INIT_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = gfpp_pkg::ST_IDLE;
                end
            end
            gfpp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = gfpp_pkg::ST_DECODE;
                end
            end
            gfpp_pkg::ST_DECODE:
            begin
                unique case (status.func)
                    gfpp_pkg::FUNC_WRITE:
                        state_next = status.page_ok ? gfpp_pkg::ST_WR_RD : gfpp_pkg::ST_RESP;
                    gfpp_pkg::FUNC_READ:
                        state_next = status.read_ok ? gfpp_pkg::ST_RD_RD : gfpp_pkg::ST_RESP;
                    gfpp_pkg::FUNC_CLEAR:
                        state_next = gfpp_pkg::ST_CLR;
                    default:
                        state_next = gfpp_pkg::ST_RESP;
                endcase
            end
            gfpp_pkg::ST_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                begin
                    state_next = gfpp_pkg::ST_RESP;
                end
            end
            gfpp_pkg::ST_WR_RD:
            begin
                if (status.col_ok)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = gfpp_pkg::ST_WR_WR;
                end
                else
                begin
                    state_next = gfpp_pkg::ST_RESP;
                end
            end
            gfpp_pkg::ST_WR_WR:
            begin
                cmd.wr_en  = 1'b1;
                state_next = status.col_last ? gfpp_pkg::ST_RESP : gfpp_pkg::ST_WR_RD;
            end
            gfpp_pkg::ST_RD_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = gfpp_pkg::ST_RESP;
            end
            gfpp_pkg::ST_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = gfpp_pkg::ST_IDLE;
            end
        endcase
    end

    `GFPP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `GFPP_ASSERT_NEXT(a_resp_idle, cmd.respond, !busy, "block still busy after response")
    `GFPP_ASSERT_NEXT(a_last_col, state_reg == gfpp_pkg::ST_WR_WR && status.col_last, cmd.respond, "glyph write overran its last column")
    `GFPP_ASSERT_NEXT(a_clr_hold, state_reg == gfpp_pkg::ST_CLR && !status.clr_last, state_reg == gfpp_pkg::ST_CLR, "clear sweep ended early")
    `GFPP_ASSERT_NOW(a_port_excl, cmd.rd_en, !cmd.wr_en && !cmd.clr_en, "memory read collides with a write")

endmodule

`default_nettype wire

// ----- src/glyph_framebuffer_page_packer_top.sv -----
// Start is accepted only in idle, and taken again in the done cycle; a new transaction
// is accepted only after the previous one has finished. Per column, a glyph write reads
// the memory byte and then writes it back merged with the glyph column.
// Reset is asynchronous and active low; afterwards the store is cleared one byte per cycle,
// all PAGES*COLUMNS bytes (512 by default), with busy high.
// Results are strobed on done for one cycle and the receiver cannot stall.
`default_nettype none

module glyph_framebuffer_page_packer_top #(
    parameter int COLUMNS = gfpp_pkg::COLUMNS_DEF,
    parameter int PAGES   = gfpp_pkg::PAGES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] func,
    input  wire logic [7:0] char_code,
    input  wire logic [1:0] page,
    input  wire logic [6:0] column,
    output logic            done,
    output logic [7:0]      column_byte,
    output logic            is_read_data
);

    gfpp_pkg::ctrl_cmd_t  cmd;
    gfpp_pkg::dp_status_t status;

    gfpp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    gfpp_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .char_code    (char_code),
        .page         (page),
        .column       (column),
        .status       (status),
        .column_byte  (column_byte),
        .is_read_data (is_read_data),
        .done         (done)
    );

endmodule

`default_nettype wire
